// ----- rtl/gbts_pkg.sv -----
// Shared types, codes and field layout for the gap buffer text store.
package gbts_pkg;

    localparam int CAPACITY_DEF = 4096;

    localparam int OFF_W  = 13;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_DONE
    } state_t;

endpackage

// ----- rtl/gbts_mem.sv -----
// Byte store: one write port, one registered read port.
module gbts_mem #(
    parameter int DEPTH = gbts_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [gbts_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [gbts_pkg::BYTE_W-1:0] rd_data
);
    import gbts_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/gap_buffer_text_store_top.sv -----
// Gap buffer text store: top level with request/result channels and control.
//
// Requests arrive on the s_ channel, one word per request: insert a byte,
// erase a run of bytes, or read a byte at a text offset. Each request gives
// exactly one result word on the m_ channel carrying the read byte, status,
// text length after the request and the number of bytes removed.
// Reads, rejected requests, zero-length erases and unused request codes go
// from acceptance straight to S_DONE and then to the result register. Insert
// and erase first move the gap to the offset through the single byte store,
// one byte per cycle, drain the last copy when the gap moved, then insert the
// byte or remove the bytes in S_MOVE before S_DONE and the result register.
// One request is in work at a time; s_tready is high while the block waits
// for a request. The result sits in an output register, so a new request is
// accepted while the previous result still waits for m_tready. If the
// receiver stalls with a result pending, the next finished result is held
// until the register frees up.
// Reset (aresetn low, synchronous) empties the text and drops any pending
// result. The store needs no clearing pass.
module gap_buffer_text_store_top #(
    parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // req_type[1:0], offset[14:2], data_byte[22:15], erase_length[35:23], zero pad
    input  logic [gbts_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data[7:0], status[9:8], text_length[22:10], removed_count[35:23], zero pad
    output logic [gbts_pkg::M_TDATA_W-1:0] m_tdata
);
    import gbts_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > OFF_W) ? LEN_W : OFF_W;
    localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [LEN_W-1:0]  head_reg, head_next;
    logic [LEN_W-1:0]  tail_reg, tail_next;
    logic [LEN_W-1:0]  target_reg, target_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [OFF_W-1:0]  count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              res_rd_reg, res_rd_next;
    logic [OFF_W-1:0]  res_removed_reg, res_removed_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_rd_reg, m_rd_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [OFF_W-1:0]  m_len_reg, m_len_next;
    logic [OFF_W-1:0]  m_removed_reg, m_removed_next;

    logic [REQ_W-1:0]  in_req;
    logic [OFF_W-1:0]  in_off;
    logic [BYTE_W-1:0] in_byte;
    logic [OFF_W-1:0]  in_count;

    logic              accept;
    logic              load_out;
    logic [LEN_W-1:0]  len;
    logic [CW-1:0]     len_c;
    logic [CW-1:0]     off_c;
    logic [LEN_W-1:0]  gap;
    logic [LEN_W-1:0]  fetch_pos;
    logic [CW-1:0]     cnt_c;
    logic [CW-1:0]     tail_c;
    logic [CW-1:0]     rem_c;
    logic              acc_move;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    assign in_req   = s_tdata[1:0];
    assign in_off   = s_tdata[14:2];
    assign in_byte  = s_tdata[22:15];
    assign in_count = s_tdata[35:23];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign len    = head_reg + tail_reg;
    assign len_c  = CW'(len);
    assign off_c  = CW'(in_off);
    assign gap    = CAP_L - head_reg - tail_reg;
    assign cnt_c  = CW'(count_reg);
    assign tail_c = CW'(tail_reg);
    assign rem_c  = (cnt_c < tail_c) ? cnt_c : tail_c;
    assign fetch_pos = (off_c < CW'(head_reg)) ? off_c[LEN_W-1:0]
                                               : off_c[LEN_W-1:0] + gap;

    gbts_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        acc_move = 1'b0;
        case (in_req)
            REQ_INSERT: acc_move = (off_c <= len_c) && (len_c < CW'(CAPACITY));
            REQ_ERASE:  acc_move = (in_count != '0) && (off_c <= len_c);
            default:    acc_move = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = acc_move ? S_MOVE : S_DONE;
                end
            end
            S_MOVE: begin
                if (head_reg == target_reg && !pend_valid_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        target_next      = target_reg;
        op_next          = op_reg;
        data_next        = data_reg;
        count_next       = count_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        res_status_next  = res_status_reg;
        res_rd_next      = res_rd_reg;
        res_removed_next = res_removed_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_rd_next        = m_rd_reg;
        m_status_next    = m_status_reg;
        m_len_next       = m_len_reg;
        m_removed_next   = m_removed_reg;
        wr_en            = 1'b0;
        wr_addr          = pend_addr_reg;
        wr_data          = rd_data;
        rd_en            = 1'b0;
        rd_addr          = fetch_pos[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next          = in_req;
                    data_next        = in_byte;
                    count_next       = in_count;
                    target_next      = off_c[LEN_W-1:0];
                    res_status_next  = ST_OK;
                    res_rd_next      = 1'b0;
                    res_removed_next = '0;
                    pend_valid_next  = 1'b0;
                    case (in_req)
                        REQ_INSERT: begin
                            if (off_c > len_c) begin
                                res_status_next = ST_RANGE;
                            end else if (len_c >= CW'(CAPACITY)) begin
                                res_status_next = ST_FULL;
                            end
                        end
                        REQ_ERASE: begin
                            if (in_count != '0 && off_c > len_c) begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        REQ_READ: begin
                            if (off_c >= len_c) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                res_rd_next = 1'b1;
                                rd_en       = 1'b1;
                            end
                        end
                        default: res_status_next = ST_OK;
                    endcase
                end
            end
            S_MOVE: begin
                if (pend_valid_reg) begin
                    wr_en = 1'b1;
                end
                if (head_reg > target_reg) begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(head_reg - 1'b1);
                    pend_addr_next  = AW'(CAP_L - tail_reg - 1'b1);
                    head_next       = head_reg - 1'b1;
                    tail_next       = tail_reg + 1'b1;
                    pend_valid_next = 1'b1;
                end else if (head_reg < target_reg) begin
                    rd_en           = 1'b1;
                    rd_addr         = AW'(CAP_L - tail_reg);
                    pend_addr_next  = AW'(head_reg);
                    head_next       = head_reg + 1'b1;
                    tail_next       = tail_reg - 1'b1;
                    pend_valid_next = 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg) begin
                        if (op_reg == REQ_INSERT) begin
                            wr_en     = 1'b1;
                            wr_addr   = AW'(head_reg);
                            wr_data   = data_reg;
                            head_next = head_reg + 1'b1;
                        end else begin
                            tail_next        = tail_reg - rem_c[LEN_W-1:0];
                            res_removed_next = rem_c[OFF_W-1:0];
                        end
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    m_valid_next   = 1'b1;
                    m_rd_next      = res_rd_reg ? rd_data : '0;
                    m_status_next  = res_status_reg;
                    m_len_next     = len_c[OFF_W-1:0];
                    m_removed_next = res_removed_reg;
                end
            end
            default: pend_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        target_reg      <= target_next;
        op_reg          <= op_next;
        data_reg        <= data_next;
        count_reg       <= count_next;
        pend_addr_reg   <= pend_addr_next;
        res_status_reg  <= res_status_next;
        res_rd_reg      <= res_rd_next;
        res_removed_reg <= res_removed_next;
        m_rd_reg        <= m_rd_next;
        m_status_reg    <= m_status_next;
        m_len_reg       <= m_len_next;
        m_removed_reg   <= m_removed_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_removed_reg, m_len_reg, m_status_reg, m_rd_reg};

    a_len_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, head_reg} + {1'b0, tail_reg}) <= (LEN_W + 1)'(CAPACITY))
        else $error("text length exceeds capacity");

    a_copy_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE && head_reg != target_reg) |=> pend_valid_reg)
        else $error("gap move read issued without pending write");

    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> !pend_valid_reg)
        else $error("result formed with gap copy still pending");

    a_idle_holds_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |=> $stable(len))
        else $error("text length changed outside gap move");

endmodule
